// ===== hdl/gtbp_pkg.sv =====
// Shared constants for the gshare-based tagged branch predictor.
package gtbp_pkg;

  localparam int BASE_INDEX_BITS_DEF = 16;
  localparam int NUM_COMPONENTS_DEF  = 3;
  localparam int FIRST_COMP_BITS_DEF = 5;

  localparam int HIST_W = 16;
  localparam int CNT_W  = 32;

  localparam logic [1:0]       CTR_MAX      = 2'd3;
  localparam logic [1:0]       CTR_MIN      = 2'd0;
  localparam logic [CNT_W-1:0] USEFUL_LIMIT = 32'd255;
  localparam logic [1:0]       BASE_CODE    = 2'd3;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  // Saturating 2-bit counter step
  function automatic logic [1:0] sat_move(input logic [1:0] v, input logic up);
    logic [1:0] r;
    r = v;
    if (up) begin
      if (v != CTR_MAX) r = v + 2'd1;
    end else begin
      if (v != CTR_MIN) r = v - 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/gshare_tagged_branch_predictor.sv =====
// Top level: gshare base table plus tagged components; each item reads the RAMs, an update writes one back.
//
// Each item (predict when s_tuser is 0, update when it is 1) is taken in two steps. On
// acceptance the base RAM and every component RAM are read. In the execute state the
// block picks the prediction or writes the trained entry back, and waits there while the
// output register still holds an untaken result. A new item is taken once the block is
// back in its accept state, while a previous result may still wait in the output register.
// After reset the base RAM and the component RAMs are swept to zero, one row per cycle. No
// item is accepted during the sweep. When the useful-reset count clears every useful bit,
// a second sweep zeroes the useful RAMs, and no item is accepted until it ends. The result
// carries the prediction (zero on update) and the provider: component 0.. or 3 for base.
module gshare_tagged_branch_predictor #(
  parameter int BASE_INDEX_BITS = gtbp_pkg::BASE_INDEX_BITS_DEF,
  parameter int NUM_COMPONENTS  = gtbp_pkg::NUM_COMPONENTS_DEF,
  parameter int FIRST_COMP_BITS = gtbp_pkg::FIRST_COMP_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // [31:0] pc, [32] resolved_taken, [33] predicted_taken
  input  logic        s_tuser,  // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // [0] prediction, [2:1] provider_id
);

  localparam int BASE_SIZE  = 1 << BASE_INDEX_BITS;
  localparam int TAG_W      = FIRST_COMP_BITS + NUM_COMPONENTS - 1;
  localparam int CLR_W      = (BASE_INDEX_BITS > TAG_W) ? BASE_INDEX_BITS : TAG_W;
  localparam int PW         = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_UCLR} state_t;

  state_t state;

  // Sweep over the RAMs after reset and on a useful clear
  logic             clr_active;
  logic [CLR_W-1:0] clr_addr;

  // Architectural registers
  logic [gtbp_pkg::HIST_W-1:0] hist;
  logic                        table_select;
  logic [gtbp_pkg::CNT_W-1:0]  useful_cnt;
  logic                        prov_base;
  logic [PW-1:0]               prov_idx;
  logic                        alt_pred;

  // Captured item
  logic        cmd_r;
  logic [31:0] pc_r;
  logic        res_r;
  logic        pred_r;

  // RAM read data
  logic [3:0]       base_rd;
  logic [TAG_W-1:0] tag_rd    [NUM_COMPONENTS];
  logic [1:0]       ctr_rd    [NUM_COMPONENTS];
  logic             useful_rd [NUM_COMPONENTS];

  logic [31:0]      pcx_in;
  logic [31:0]      pcx_r;
  logic [TAG_W-1:0] ctag_r   [NUM_COMPONENTS];

  logic in_xfer;
  logic done;
  logic upd_comp;

  assign s_tready = (state == S_IDLE) && !clr_active;
  assign in_xfer  = s_tvalid && s_tready;
  assign done     = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign upd_comp = (cmd_r == gtbp_pkg::CMD_UPDATE) && !prov_base;

  assign pcx_in = s_tdata[31:0] ^ {{(32 - gtbp_pkg::HIST_W){1'b0}}, hist};
  assign pcx_r  = pc_r ^ {{(32 - gtbp_pkg::HIST_W){1'b0}}, hist};

  // Base RAM: one row holds the counters of both base tables
  logic [3:0] base_mem [BASE_SIZE];
  logic [BASE_INDEX_BITS-1:0] base_widx;
  logic [1:0] base_new;
  logic [3:0] base_wdata;

  assign base_widx  = pcx_r[BASE_INDEX_BITS-1:0];
  assign base_new   = gtbp_pkg::sat_move(table_select ? base_rd[3:2] : base_rd[1:0], res_r);
  assign base_wdata = table_select ? {base_new, base_rd[1:0]} : {base_rd[3:2], base_new};

  always_ff @(posedge clk) begin
    if (clr_active) begin
      base_mem[clr_addr[BASE_INDEX_BITS-1:0]] <= 4'd0;
    end else if (done && cmd_r == gtbp_pkg::CMD_UPDATE && prov_base) begin
      base_mem[base_widx] <= base_wdata;
    end
    if (in_xfer) begin
      base_rd <= base_mem[pcx_in[BASE_INDEX_BITS-1:0]];
    end
  end

  // Tagged component RAMs, one tag/counter RAM and one useful RAM per component
  logic [1:0] ctr_new;
  logic       realloc;
  logic       set_useful;

  for (genvar c = 0; c < NUM_COMPONENTS; c++) begin : g_comp
    localparam int SZB = FIRST_COMP_BITS + c;
    logic [TAG_W+1:0] mem  [1 << SZB];
    logic             umem [1 << SZB];
    logic [TAG_W-1:0] tag_q;
    logic [1:0]       ctr_q;
    logic             use_q;

    assign ctag_r[c]    = TAG_W'(pc_r[SZB-1:0]);
    assign tag_rd[c]    = tag_q;
    assign ctr_rd[c]    = ctr_q;
    assign useful_rd[c] = use_q;

    always_ff @(posedge clk) begin
      if (clr_active) begin
        mem[clr_addr[SZB-1:0]] <= '0;
      end else if (done && upd_comp && prov_idx == PW'(c)) begin
        mem[pcx_r[SZB-1:0]] <= {realloc ? ctag_r[c] : tag_q, ctr_new};
      end
      if (clr_active || state == S_UCLR) begin
        umem[clr_addr[SZB-1:0]] <= 1'b0;
      end else if (done && upd_comp && prov_idx == PW'(c)) begin
        umem[pcx_r[SZB-1:0]] <= realloc ? 1'b0 : (set_useful ? 1'b1 : use_q);
      end
      if (in_xfer) begin
        {tag_q, ctr_q} <= mem[pcx_in[SZB-1:0]];
        use_q <= umem[pcx_in[SZB-1:0]];
      end
    end
  end

  // Prediction: highest-numbered tag hit with a saturated counter wins, else the base
  logic          pdir;
  logic          pbase;
  logic [PW-1:0] pidx;
  logic          base_dir;

  assign base_dir = (table_select ? base_rd[3:2] : base_rd[1:0]) > 2'd1;

  always_comb begin
    pdir  = base_dir;
    pbase = 1'b1;
    pidx  = '0;
    for (int c = 0; c < NUM_COMPONENTS; c++) begin
      if (tag_rd[c] == ctag_r[c] &&
          (ctr_rd[c] == gtbp_pkg::CTR_MAX || ctr_rd[c] == gtbp_pkg::CTR_MIN)) begin
        pdir  = (ctr_rd[c] == gtbp_pkg::CTR_MAX);
        pbase = 1'b0;
        pidx  = PW'(c);
      end
    end
  end

  // Component training for the recorded provider
  logic [1:0]                 sel_ctr;
  logic                       sel_useful;
  logic [gtbp_pkg::CNT_W-1:0] cnt1;
  logic                       clear_all;

  always_comb begin
    sel_ctr    = ctr_rd[0];
    sel_useful = useful_rd[0];
    for (int c = 0; c < NUM_COMPONENTS; c++) begin
      if (prov_idx == PW'(c)) begin
        sel_ctr    = ctr_rd[c];
        sel_useful = useful_rd[c];
      end
    end
  end

  assign cnt1 = sel_useful ? useful_cnt + 1'b1 :
                (useful_cnt != '0 ? useful_cnt - 1'b1 : useful_cnt);
  assign set_useful = (res_r == pred_r) && (res_r != alt_pred);
  assign clear_all  = set_useful && (cnt1 >= gtbp_pkg::USEFUL_LIMIT);
  assign realloc    = (res_r != pred_r);
  assign ctr_new    = gtbp_pkg::sat_move(realloc ? 2'd0 : sel_ctr, res_r);

  logic [1:0] code;
  assign code = pbase ? gtbp_pkg::BASE_CODE : 2'(pidx);

  logic [1:0] prov_code;
  assign prov_code = prov_base ? gtbp_pkg::BASE_CODE : 2'(prov_idx);

  // Control, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      clr_active   <= 1'b1;
      clr_addr     <= '0;
      hist         <= '0;
      table_select <= 1'b1;
      useful_cnt   <= '0;
      prov_base    <= 1'b1;
      prov_idx     <= '0;
      alt_pred     <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == {CLR_W{1'b1}}) clr_active <= 1'b0;
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cmd_r  <= s_tuser;
            pc_r   <= s_tdata[31:0];
            res_r  <= s_tdata[32];
            pred_r <= s_tdata[33];
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (done) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
            if (cmd_r == gtbp_pkg::CMD_PREDICT) begin
              alt_pred  <= base_dir;
              prov_base <= pbase;
              prov_idx  <= pidx;
              m_tdata   <= {5'd0, code, pdir};
            end else begin
              m_tdata <= {5'd0, prov_code, 1'b0};
              hist    <= {hist[gtbp_pkg::HIST_W-2:0], res_r};
              if (prov_base) begin
                table_select <= res_r;
              end else begin
                useful_cnt <= cnt1;
                if (clear_all) begin
                  useful_cnt <= '0;
                  clr_addr   <= '0;
                  state      <= S_UCLR;
                end
              end
            end
          end
        end
        S_UCLR: begin
          // Zero every useful bit, one row per cycle
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr[TAG_W-1:0] == {TAG_W{1'b1}}) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/gshare_tagged_branch_predictor_test.sv =====
// Self-checking stream testbench for the gshare-based tagged branch predictor.
`timescale 1ns / 1ps

module gshare_tagged_branch_predictor_test;

  localparam int BIB = gtbp_pkg::BASE_INDEX_BITS_DEF;
  localparam int NC = gtbp_pkg::NUM_COMPONENTS_DEF;
  localparam int FCB = gtbp_pkg::FIRST_COMP_BITS_DEF;
  localparam int BSIZE = 1 << BIB;
  localparam int CTOTAL = (1 << FCB) * ((1 << NC) - 1);
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic        cmd;
    logic [31:0] pc;
    logic        resolved;
    logic        predicted;
  } branch_op_t;

  typedef struct packed {
    logic       taken;
    logic [1:0] provider;
  } branch_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  gshare_tagged_branch_predictor i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor shadow state
  logic [1:0]  base_ctr [2][BSIZE];
  logic [15:0] ctag [CTOTAL];
  logic [1:0]  cctr [CTOTAL];
  logic        cuse [CTOTAL];
  logic [15:0] ghist;
  logic        tsel;
  logic [31:0] useful_cnt;
  int          last_prov;
  logic        alt_dir;

  branch_op_t  pending_ops [$];
  branch_res_t expected_res [$];
  int errors = 0;
  int n_pred = 0, n_upd = 0, n_comp_hits = 0;
  bit hold_sink = 0;

  function automatic logic [1:0] ctr_step(logic [1:0] v, logic up);
    if (up) return (v == 2'd3) ? v : v + 2'd1;
    return (v == 2'd0) ? v : v - 2'd1;
  endfunction

  function automatic int slot_of(int c, logic [31:0] pc);
    int sz;
    sz = 1 << (FCB + c);
    return (1 << FCB) * ((1 << c) - 1) + int'((pc ^ {16'd0, ghist}) & (sz - 1));
  endfunction

  function automatic void predict_branch(branch_op_t op, output branch_res_t r);
    int s, sz;
    logic dir;
    if (op.cmd == gtbp_pkg::CMD_PREDICT) begin
      dir = base_ctr[tsel][int'((op.pc ^ {16'd0, ghist}) & (BSIZE - 1))] > 2'd1;
      alt_dir = dir;
      last_prov = NC;
      for (int c = 0; c < NC; c++) begin
        s = slot_of(c, op.pc);
        sz = 1 << (FCB + c);
        if (ctag[s] == 16'(op.pc & (sz - 1)) && (cctr[s] == 2'd3 || cctr[s] == 2'd0)) begin
          dir = cctr[s] == 2'd3;
          last_prov = c;
        end
      end
      r.taken = dir;
    end else begin
      r.taken = 1'b0;
      if (last_prov >= NC) begin
        s = int'((op.pc ^ {16'd0, ghist}) & (BSIZE - 1));
        base_ctr[tsel][s] = ctr_step(base_ctr[tsel][s], op.resolved);
        tsel = op.resolved;
      end else begin
        s = slot_of(last_prov, op.pc);
        sz = 1 << (FCB + last_prov);
        if (!cuse[s]) begin
          if (useful_cnt != 0) useful_cnt--;
        end else useful_cnt++;
        if (op.resolved == op.predicted && op.resolved != alt_dir) begin
          cuse[s] = 1'b1;
          if (useful_cnt >= gtbp_pkg::USEFUL_LIMIT) begin
            foreach (cuse[i]) cuse[i] = 1'b0;
            useful_cnt = 0;
          end
        end
        if (op.resolved != op.predicted) begin
          ctag[s] = 16'(op.pc & (sz - 1));
          cctr[s] = 2'd0;
          cuse[s] = 1'b0;
        end
        cctr[s] = ctr_step(cctr[s], op.resolved);
      end
      ghist = {ghist[14:0], op.resolved};
    end
    r.provider = (last_prov >= NC) ? gtbp_pkg::BASE_CODE : 2'(last_prov);
  endfunction

  // Driver: offers queued items with random gaps
  always @(posedge clk) begin
    branch_op_t op;
    branch_res_t r;
    int gap;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        op = {s_tuser, s_tdata[31:0], s_tdata[32], s_tdata[33]};
        predict_branch(op, r);
        expected_res.push_back(r);
        if (op.cmd == gtbp_pkg::CMD_PREDICT) begin
          n_pred++;
          if (r.provider != gtbp_pkg::BASE_CODE) n_comp_hits++;
        end else n_upd++;
      end
      if (!s_tvalid || s_tready) begin
        gap = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
        if ($urandom_range(0, 60) == 0) gap = $urandom_range(10, 30);
        if (pending_ops.size() != 0 && gap == 0) begin
          op = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= op.cmd;
          s_tdata <= {6'd0, op.predicted, op.resolved, op.pc};
        end else s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random backpressure and result checking
  always @(posedge clk) begin
    branch_res_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result transfer: %h", m_tdata);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (m_tdata[0] !== e.taken) begin
            $error("prediction: expected %0d actual %0d", e.taken, m_tdata[0]);
            errors++;
          end
          if (m_tdata[2:1] !== e.provider) begin
            $error("provider_id: expected %0d actual %0d", e.provider, m_tdata[2:1]);
            errors++;
          end
        end
      end
      m_tready <= !hold_sink && ($urandom_range(0, 9) < 7);
    end
  end

  // Timeout
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One long sink stall while the source keeps offering
  initial begin
    wait (!rst && n_pred + n_upd > 40);
    hold_sink = 1;
    repeat (200) @(posedge clk);
    hold_sink = 0;
  end

  task automatic push_op(logic cmd, logic [31:0] pc, logic res, logic pr);
    branch_op_t op;
    op.cmd = cmd; op.pc = pc; op.resolved = res; op.predicted = pr;
    pending_ops.push_back(op);
  endtask

  initial begin
    logic [31:0] pc;
    logic [31:0] hot [8];
    logic r;
    foreach (base_ctr[t, i]) base_ctr[t][i] = 2'd0;
    foreach (ctag[i]) begin
      ctag[i] = '0; cctr[i] = '0; cuse[i] = 1'b0;
    end
    ghist = '0; tsel = 1'b1; useful_cnt = '0; last_prov = NC; alt_dir = 1'b0;

    // Directed: extremes, base training, component hits, repeated updates
    push_op(gtbp_pkg::CMD_PREDICT, 32'h0, 1'b0, 1'b0);
    push_op(gtbp_pkg::CMD_UPDATE, 32'h0, 1'b1, 1'b0);
    push_op(gtbp_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_op(gtbp_pkg::CMD_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_op(gtbp_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_op(gtbp_pkg::CMD_PREDICT, 32'hDEAD_BEEF, 1'b0, 1'b0);
    push_op(gtbp_pkg::CMD_UPDATE, 32'hDEAD_BEEF, 1'b1, 1'b0);
    push_op(gtbp_pkg::CMD_UPDATE, 32'hDEAD_BEEF, 1'b1, 1'b1);
    push_op(gtbp_pkg::CMD_PREDICT, 32'h8000_0000, 1'b0, 1'b0);
    push_op(gtbp_pkg::CMD_UPDATE, 32'h8000_0000, 1'b0, 1'b0);
    for (int i = 0; i < 10; i++) begin
      push_op(i[0] ? gtbp_pkg::CMD_UPDATE : gtbp_pkg::CMD_PREDICT, 32'h0000_0040, 1'b0, 1'b1);
    end

    // Random: hot branches give component hits; mispredict updates reallocate
    foreach (hot[i]) hot[i] = $urandom();
    for (int i = 0; i < 420; i++) begin
      pc = ($urandom_range(0, 3) == 0) ? $urandom() : hot[$urandom_range(0, 7)];
      r = $urandom_range(0, 1);
      push_op(gtbp_pkg::CMD_PREDICT, pc, $urandom_range(0, 1), $urandom_range(0, 1));
      push_op(gtbp_pkg::CMD_UPDATE, pc, r, ($urandom_range(0, 3) == 0) ? !r : r);
      if ($urandom_range(0, 15) == 0)
        push_op(gtbp_pkg::CMD_UPDATE, pc, $urandom_range(0, 1), $urandom_range(0, 1));
    end

    wait (!rst && pending_ops.size() == 0 && !s_tvalid);
    wait (expected_res.size() == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d predicts (%0d from tagged components) and %0d updates",
             n_pred, n_comp_hits, n_upd);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Reset once
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

endmodule
